@@ rtl/tsb_pkg.sv @@
// Shared constants and types of the tube segment builder.
package tsb_pkg;

  localparam int TUBES_DEF = 3;

  localparam int TRANS_W = 21;
  localparam int LEN_W   = 20;
  localparam int WORD_W  = 32;
  localparam int ARC_W   = 21;
  localparam int PT_W    = 24;
  localparam int DIFF_W  = 23;

  localparam int RECIP_W  = 23;
  localparam int RECIP_SH = 26;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int QUOT_W   = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP = 23'd6710887;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_PROX = 2'd1,
    STATUS_DIST = 2'd2
  } status_e;

endpackage

@@ rtl/tube_segment_builder.sv @@
// Top level of the tube segment builder: tube table, sequencer and shared adder.
//
// Tube items are taken while the block is idle. The item flagged last_tube
// starts the computation, during which the block is not ready: it forms the
// tips and bend starts, loads the points, ranks the points (one compare per
// cycle in the shared adder) and checks for clashes; a clash gives a single
// status row. Otherwise it forms the end arc of each segment and a result row
// per tube and segment, held while out_ready_i is low. A full set with three
// tubes has 18 rows. The rank loop runs through the single adder.
module tube_segment_builder #(
  parameter int TUBES = tsb_pkg::TUBES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          tube_index_i,
  input  logic signed [tsb_pkg::TRANS_W-1:0]  translation_i,
  input  logic [tsb_pkg::LEN_W-1:0]           tube_length_i,
  input  logic [tsb_pkg::LEN_W-1:0]           curved_length_i,
  input  logic [tsb_pkg::WORD_W-1:0]          bend_stiffness_i,
  input  logic [tsb_pkg::WORD_W-1:0]          torsion_stiffness_i,
  input  logic signed [tsb_pkg::WORD_W-1:0]   precurvature_i,
  input  logic                                last_tube_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          segment_index_o,
  output logic [1:0]                          out_tube_o,
  output logic [tsb_pkg::ARC_W-1:0]           segment_end_arc_o,
  output logic [tsb_pkg::WORD_W-1:0]          seg_bend_stiffness_o,
  output logic [tsb_pkg::WORD_W-1:0]          seg_torsion_stiffness_o,
  output logic signed [tsb_pkg::WORD_W-1:0]   seg_precurvature_o,
  output logic signed [3:0]                   tube_last_segment_o,
  output logic [1:0]                          status_o,
  output logic                                last_result_o
);
  import tsb_pkg::*;

  localparam int NPTS   = 2 * TUBES + 1;
  localparam int NSEG   = 2 * TUBES;
  localparam int PIDX_W = $clog2(NPTS);
  localparam int TIDX_W = (TUBES > 1) ? $clog2(TUBES) : 1;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_TIP   = 15'b000000000000010,
    S_BEND  = 15'b000000000000100,
    S_LOAD  = 15'b000000000001000,
    S_RANK  = 15'b000000000010000,
    S_CPRE  = 15'b000000000100000,
    S_CPROX = 15'b000000001000000,
    S_CDIST = 15'b000000010000000,
    S_SPRE  = 15'b000000100000000,
    S_DIFF  = 15'b000001000000000,
    S_MUL   = 15'b000010000000000,
    S_TEN   = 15'b000100000000000,
    S_ACC   = 15'b001000000000000,
    S_ROW   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [TRANS_W-1:0] tb_trans_q [TUBES];
  logic [LEN_W-1:0]          tb_len_q   [TUBES];
  logic [LEN_W-1:0]          tb_curv_q  [TUBES];
  logic [WORD_W-1:0]         tb_bend_q  [TUBES];
  logic [WORD_W-1:0]         tb_tors_q  [TUBES];
  logic [WORD_W-1:0]         tb_prec_q  [TUBES];

  logic signed [PT_W-1:0] tip_q    [TUBES];
  logic signed [PT_W-1:0] bstart_q [TUBES];
  logic signed [PT_W-1:0] ring_q   [NPTS];
  logic signed [PT_W-1:0] cand_q   [NPTS];
  logic signed [PT_W-1:0] sorted_q [NPTS];

  logic [PIDX_W-1:0] zero_pos_q;
  logic [PIDX_W-1:0] bend_pos_q [TUBES];
  logic [PIDX_W-1:0] tip_pos_q  [TUBES];

  logic [TIDX_W-1:0] idx_q, idx_d;
  logic [PIDX_W-1:0] a_q, a_d;
  logic [PIDX_W-1:0] b_q, b_d;
  logic [PIDX_W-1:0] cnt_q, cnt_d;
  logic [PIDX_W-1:0] pt_q, pt_d;

  logic signed [PT_W-1:0] prev_q;
  logic signed [PT_W-1:0] prev_tip_q;
  logic [DIFF_W-1:0]      diff_q;
  logic [PROD_W-1:0]      prod_q;
  logic [DIFF_W-1:0]      fl_q;
  logic signed [PT_W-1:0] arc_q;

  logic [2:0]               seg_index_q;
  logic [1:0]               out_tube_q;
  logic [ARC_W-1:0]         arc_out_q;
  logic [WORD_W-1:0]        bend_out_q;
  logic [WORD_W-1:0]        tors_out_q;
  logic signed [WORD_W-1:0] prec_out_q;
  logic signed [3:0]        last_seg_q;
  status_e                  status_q;
  logic                     last_q;

  logic signed [PT_W-1:0] alu_a, alu_b, alu_y;
  logic                   alu_sub, alu_neg, alu_zero;

  logic                   in_fire, out_fire, idx_ok;
  logic signed [PT_W-1:0] rd_trans, rd_len, rd_curv, rd_sorted;
  logic [PIDX_W-1:0]      sorted_addr;
  logic                   precedes;
  logic [PIDX_W-1:0]      cnt_inc;
  logic [PIDX_W-1:0]      seg_j, seg_rel;
  logic [PIDX_W:0]        last_seg_w;
  logic                   exists, curved, row_last;
  logic [QUOT_W-1:0]      quot;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign idx_ok      = ({1'b0, tube_index_i} < 3'(TUBES));

  assign rd_trans = PT_W'(tb_trans_q[idx_q]);
  assign rd_len   = $signed({{(PT_W-LEN_W){1'b0}}, tb_len_q[idx_q]});
  assign rd_curv  = $signed({{(PT_W-LEN_W){1'b0}}, tb_curv_q[idx_q]});

  assign sorted_addr = (state_q == S_SPRE) ? zero_pos_q : pt_q;
  assign rd_sorted   = sorted_q[sorted_addr];

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_TIP: begin
        alu_a = rd_trans;
        alu_b = rd_len;
      end
      S_BEND: begin
        alu_a   = tip_q[idx_q];
        alu_b   = rd_curv;
        alu_sub = 1'b1;
      end
      S_RANK: begin
        alu_a   = ring_q[0];
        alu_b   = cand_q[0];
        alu_sub = 1'b1;
      end
      S_CPROX: begin
        alu_a   = rd_trans;
        alu_b   = prev_q;
        alu_sub = 1'b1;
      end
      S_CDIST: begin
        alu_a   = prev_tip_q;
        alu_b   = tip_q[idx_q];
        alu_sub = 1'b1;
      end
      S_DIFF: begin
        alu_a   = rd_sorted;
        alu_b   = prev_q;
        alu_sub = 1'b1;
      end
      S_ACC: begin
        alu_a = arc_q;
        alu_b = $signed({{(PT_W-DIFF_W){1'b0}}, fl_q});
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_y    = alu_a + (alu_sub ? ~alu_b : alu_b) + PT_W'(alu_sub);
  assign alu_neg  = alu_y[PT_W-1];
  assign alu_zero = (alu_y == '0);

  assign precedes = alu_neg || (alu_zero && (b_q < a_q));
  assign cnt_inc  = cnt_q + PIDX_W'(precedes);

  assign seg_j      = pt_q - PIDX_W'(1);
  assign seg_rel    = seg_j - zero_pos_q;
  assign exists     = seg_j < tip_pos_q[idx_q];
  assign curved     = exists && (seg_j >= bend_pos_q[idx_q]);
  assign last_seg_w = {1'b0, tip_pos_q[idx_q]} - {1'b0, zero_pos_q} - (PIDX_W+1)'(1);
  assign row_last   = (pt_q == PIDX_W'(NSEG)) && (idx_q == TIDX_W'(TUBES - 1));
  assign quot       = prod_q[RECIP_SH +: QUOT_W];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    a_d     = a_q;
    b_d     = b_q;
    cnt_d   = cnt_q;
    pt_d    = pt_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && last_tube_i) begin
          idx_d   = '0;
          state_d = S_TIP;
        end
      end
      S_TIP: begin
        state_d = S_BEND;
      end
      S_BEND: begin
        if (idx_q == TIDX_W'(TUBES - 1)) begin
          state_d = S_LOAD;
        end else begin
          idx_d   = idx_q + TIDX_W'(1);
          state_d = S_TIP;
        end
      end
      S_LOAD: begin
        a_d     = '0;
        b_d     = '0;
        cnt_d   = '0;
        state_d = S_RANK;
      end
      S_RANK: begin
        if (b_q == PIDX_W'(NPTS - 1)) begin
          b_d   = '0;
          cnt_d = '0;
          a_d   = a_q + PIDX_W'(1);
          if (a_q == PIDX_W'(NPTS - 1)) begin
            idx_d   = '0;
            state_d = (TUBES > 1) ? S_CPRE : S_SPRE;
          end
        end else begin
          b_d   = b_q + PIDX_W'(1);
          cnt_d = cnt_inc;
        end
      end
      S_CPRE: begin
        idx_d   = idx_q + TIDX_W'(1);
        state_d = S_CPROX;
      end
      S_CPROX: begin
        state_d = alu_neg ? S_OUT : S_CDIST;
      end
      S_CDIST: begin
        if (alu_neg) begin
          state_d = S_OUT;
        end else if (idx_q == TIDX_W'(TUBES - 1)) begin
          state_d = S_SPRE;
        end else begin
          idx_d   = idx_q + TIDX_W'(1);
          state_d = S_CPROX;
        end
      end
      S_SPRE: begin
        pt_d    = zero_pos_q + PIDX_W'(1);
        state_d = (zero_pos_q == PIDX_W'(NSEG)) ? S_IDLE : S_DIFF;
      end
      S_DIFF: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_TEN;
      end
      S_TEN: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        idx_d   = '0;
        state_d = S_ROW;
      end
      S_ROW: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else if (idx_q == TIDX_W'(TUBES - 1)) begin
            pt_d    = pt_q + PIDX_W'(1);
            state_d = S_DIFF;
          end else begin
            idx_d   = idx_q + TIDX_W'(1);
            state_d = S_ROW;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      cnt_q   <= '0;
      pt_q    <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      a_q     <= a_d;
      b_q     <= b_d;
      cnt_q   <= cnt_d;
      pt_q    <= pt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire && idx_ok) begin
          tb_trans_q[TIDX_W'(tube_index_i)] <= translation_i;
          tb_len_q[TIDX_W'(tube_index_i)]   <= tube_length_i;
          tb_curv_q[TIDX_W'(tube_index_i)]  <= curved_length_i;
          tb_bend_q[TIDX_W'(tube_index_i)]  <= bend_stiffness_i;
          tb_tors_q[TIDX_W'(tube_index_i)]  <= torsion_stiffness_i;
          tb_prec_q[TIDX_W'(tube_index_i)]  <= precurvature_i;
        end
      end
      S_TIP: begin
        tip_q[idx_q] <= alu_y;
      end
      S_BEND: begin
        bstart_q[idx_q] <= alu_y;
      end
      S_LOAD: begin
        ring_q[0] <= '0;
        cand_q[0] <= '0;
        for (int k = 0; k < TUBES; k++) begin
          ring_q[1 + k]         <= bstart_q[k];
          ring_q[1 + TUBES + k] <= tip_q[k];
          cand_q[1 + k]         <= bstart_q[k];
          cand_q[1 + TUBES + k] <= tip_q[k];
        end
      end
      S_RANK: begin
        for (int m = 0; m < NPTS; m++) begin
          ring_q[m] <= ring_q[(m + 1) % NPTS];
        end
        if (b_q == PIDX_W'(NPTS - 1)) begin
          sorted_q[cnt_inc] <= cand_q[0];
          for (int m = 0; m < NPTS; m++) begin
            cand_q[m] <= cand_q[(m + 1) % NPTS];
          end
          if (a_q == '0) begin
            zero_pos_q <= cnt_inc;
          end else if (a_q <= PIDX_W'(TUBES)) begin
            bend_pos_q[TIDX_W'(a_q - PIDX_W'(1))] <= cnt_inc;
          end else begin
            tip_pos_q[TIDX_W'(a_q - PIDX_W'(1 + TUBES))] <= cnt_inc;
          end
        end
      end
      S_CPRE: begin
        prev_q     <= rd_trans;
        prev_tip_q <= tip_q[idx_q];
      end
      S_CPROX: begin
        if (alu_neg) begin
          seg_index_q <= '0;
          out_tube_q  <= 2'(idx_q - TIDX_W'(1));
          arc_out_q   <= '0;
          bend_out_q  <= '0;
          tors_out_q  <= '0;
          prec_out_q  <= '0;
          last_seg_q  <= '0;
          status_q    <= STATUS_PROX;
          last_q      <= 1'b1;
        end
      end
      S_CDIST: begin
        prev_q     <= rd_trans;
        prev_tip_q <= tip_q[idx_q];
        if (alu_neg) begin
          seg_index_q <= '0;
          out_tube_q  <= 2'(idx_q - TIDX_W'(1));
          arc_out_q   <= '0;
          bend_out_q  <= '0;
          tors_out_q  <= '0;
          prec_out_q  <= '0;
          last_seg_q  <= '0;
          status_q    <= STATUS_DIST;
          last_q      <= 1'b1;
        end
      end
      S_SPRE: begin
        prev_q <= rd_sorted;
        arc_q  <= '0;
      end
      S_DIFF: begin
        diff_q <= alu_y[DIFF_W-1:0];
        prev_q <= rd_sorted;
      end
      S_MUL: begin
        prod_q <= PROD_W'(diff_q) * PROD_W'(RECIP);
      end
      S_TEN: begin
        fl_q <= DIFF_W'({quot, 3'b000}) + DIFF_W'({quot, 1'b0});
      end
      S_ACC: begin
        arc_q <= alu_y;
      end
      S_ROW: begin
        seg_index_q <= 3'(seg_rel);
        out_tube_q  <= 2'(idx_q);
        arc_out_q   <= arc_q[ARC_W-1:0];
        bend_out_q  <= exists ? tb_bend_q[idx_q] : '0;
        tors_out_q  <= exists ? tb_tors_q[idx_q] : '0;
        prec_out_q  <= curved ? $signed(tb_prec_q[idx_q]) : '0;
        last_seg_q  <= 4'($signed(last_seg_w));
        status_q    <= STATUS_OK;
        last_q      <= row_last;
      end
      default: begin
        prev_q <= prev_q;
      end
    endcase
  end

  assign segment_index_o         = seg_index_q;
  assign out_tube_o              = out_tube_q;
  assign segment_end_arc_o       = arc_out_q;
  assign seg_bend_stiffness_o    = bend_out_q;
  assign seg_torsion_stiffness_o = tors_out_q;
  assign seg_precurvature_o      = prec_out_q;
  assign tube_last_segment_o     = last_seg_q;
  assign status_o                = status_q;
  assign last_result_o           = last_q;

endmodule

@@ rtl/tsb_checker.sv @@
// Port-level checks of the tube segment builder, bound to its top level.
module tsb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   status_o,
  input logic                         last_result_o,
  input logic [tsb_pkg::ARC_W-1:0]    segment_end_arc_o,
  input logic [tsb_pkg::WORD_W-1:0]   seg_bend_stiffness_o
);
  import tsb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(last_result_o) && $stable(segment_end_arc_o))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_err_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> last_result_o &&
    (segment_end_arc_o == '0) && (seg_bend_stiffness_o == '0))
    else $error("clash result is not a single cleared row");

  a_more_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_result_o |=> !in_ready_o)
    else $error("input taken before the final row");

endmodule

bind tube_segment_builder tsb_checker u_tsb_checker (.*);
